/* rtl/emsa_pkg.sv */
// Package for the encoder mode setpoint adjuster.
// Holds the mode codes, the field widths and the display arithmetic helpers.
// No dependencies.
package emsa_pkg;

  typedef logic [2:0] mode_t;

  // Mode codes; every mode but MODE_MONITOR selects a setpoint that the encoder adjusts.
  localparam mode_t MODE_HIGH_DUTY = 3'd1;
  localparam mode_t MODE_LOW_DUTY  = 3'd2;
  localparam mode_t MODE_MONITOR   = 3'd3;
  localparam mode_t MODE_CURRENT   = 3'd4;
  localparam mode_t MODE_VOLTAGE   = 3'd5;

  // Encoder pin pairs that give one count per detent.
  localparam logic [1:0] PINS_IDLE   = 2'b00;
  localparam logic [1:0] PINS_B_ONLY = 2'b01;

  localparam int unsigned CurrentLimitReset = 21;

  // Percent of full scale 255: x*100/255, exact for any 8-bit x.
  // Uses p/255 = (p + 1 + p/256) / 256, valid for p below 65280.
  function automatic logic [6:0] pct_of_255(input logic [7:0] x);
    logic [15:0] p;
    logic [15:0] s;
    begin
      p = 16'(x) * 16'd100;
      s = p + 16'd1 + (p >> 8);
      return s[14:8];
    end
  endfunction

  // x*100/1023 for 8-bit x, same correction with a 1024 base.
  function automatic logic [6:0] pct_of_1023(input logic [7:0] x);
    logic [15:0] p;
    logic [15:0] s;
    begin
      p = 16'(x) * 16'd100;
      s = p + 16'd1 + (p >> 10);
      return {2'b00, s[14:10]};
    end
  endfunction

  // Divide a value below 100 by ten with a reciprocal multiply.
  function automatic logic [3:0] div_by_ten(input logic [6:0] r);
    logic [17:0] m;
    begin
      m = 18'(r) * 18'd205;
      return m[14:11];
    end
  endfunction

endpackage

/* rtl/encoder_mode_setpoint_adjuster_top.sv */
// Top level of the encoder mode setpoint adjuster.
// Depends on emsa_pkg for mode codes and the display arithmetic.
//
// Each transfer on the input channel is a mode button press or one encoder pin
// sample, and it yields one result transfer with all setpoints, the display
// value and its decimal digits. The block takes one item per clock while input
// stall is low: the setpoint registers update at the input transfer, and the
// display value is computed from them and loaded into the output register when
// that register is free or its output is not stalled. The setpoint registers
// double as a holding stage in front of the output register, which lets the
// input side keep moving while one result waits; input stall rises only when
// both are full and the output is stalled. The current_limit register is
// written through its own channel, which is always ready; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module encoder_mode_setpoint_adjuster_top
  import emsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  // Input channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [1:0] enc_pins,
  // Output channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] mode,
  output logic [7:0] duty_high_side,
  output logic [7:0] duty_low_side,
  output logic [6:0] current_level,
  output logic [7:0] voltage_level,
  output logic [6:0] shown_value,
  output logic [3:0] digit_thousands,
  output logic [3:0] digit_hundreds,
  output logic [3:0] digit_tens,
  output logic [3:0] digit_units,
  output logic       point_on
);

  // Setpoint state and configuration.
  logic [6:0] current_limit;
  mode_t      mode_sel;
  logic [1:0] prev_pins;
  logic [7:0] high_duty;
  logic [7:0] low_duty;
  logic [6:0] current_lvl;
  logic [7:0] voltage_lvl;
  logic       pend_valid;

  mode_t      mode_sel_next;
  logic [1:0] prev_pins_next;
  logic [7:0] high_duty_next;
  logic [7:0] low_duty_next;
  logic [6:0] current_lvl_next;
  logic [7:0] voltage_lvl_next;

  logic in_take;
  logic out_load;
  logic count_up;
  logic count_dn;
  logic sample;

  logic [6:0] shown;
  logic       hundreds;
  logic [6:0] rem_hund;
  logic [3:0] tens;
  logic [3:0] units;

  // Handshake control. The setpoint registers hold the pending result
  // until it moves into the output register.
  assign cfg_ready = 1'b1;
  assign out_load  = pend_valid && (!out_valid || !out_stall);
  assign in_stall  = pend_valid && !out_load;
  assign in_take   = in_valid && !in_stall;

  // Quadrature decode, one count per detent.
  assign sample   = !command && (mode_sel != MODE_MONITOR);
  assign count_up = (prev_pins == PINS_B_ONLY) && (enc_pins == PINS_IDLE);
  assign count_dn = (prev_pins == PINS_IDLE) && (enc_pins == PINS_B_ONLY);

  // Next setpoint state for the item at the input.
  always_comb begin
    mode_sel_next    = mode_sel;
    prev_pins_next   = prev_pins;
    high_duty_next   = high_duty;
    low_duty_next    = low_duty;
    current_lvl_next = current_lvl;
    voltage_lvl_next = voltage_lvl;
    if (command) begin
      mode_sel_next = (mode_sel >= MODE_VOLTAGE) ? MODE_HIGH_DUTY : mode_sel + 3'd1;
    end else if (sample) begin
      prev_pins_next = enc_pins;
      case (mode_sel)
        MODE_HIGH_DUTY: begin
          if (count_up) high_duty_next = high_duty + 8'd1;
          else if (count_dn) high_duty_next = high_duty - 8'd1;
        end
        MODE_LOW_DUTY: begin
          if (count_up) low_duty_next = low_duty + 8'd1;
          else if (count_dn) low_duty_next = low_duty - 8'd1;
        end
        MODE_CURRENT: begin
          if (count_up && current_lvl < current_limit) begin
            current_lvl_next = current_lvl + 7'd1;
          end else if (count_dn && current_lvl != 7'd0) begin
            current_lvl_next = current_lvl - 7'd1;
          end
        end
        MODE_VOLTAGE: begin
          if (count_up && voltage_lvl != 8'hFF) voltage_lvl_next = voltage_lvl + 8'd1;
          else if (count_dn && voltage_lvl != 8'd0) voltage_lvl_next = voltage_lvl - 8'd1;
        end
        default: begin
        end
      endcase
      // A lowered limit pulls the current level down on any sample.
      if (current_lvl > current_limit) current_lvl_next = current_limit;
    end
  end

  // Setpoint registers, updated at each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_limit <= 7'(CurrentLimitReset);
      mode_sel      <= MODE_HIGH_DUTY;
      prev_pins     <= PINS_IDLE;
      high_duty     <= 8'd0;
      low_duty      <= 8'd0;
      current_lvl   <= 7'd0;
      voltage_lvl   <= 8'd0;
      pend_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) current_limit <= cfg_data;
      if (in_take) begin
        mode_sel    <= mode_sel_next;
        prev_pins   <= prev_pins_next;
        high_duty   <= high_duty_next;
        low_duty    <= low_duty_next;
        current_lvl <= current_lvl_next;
        voltage_lvl <= voltage_lvl_next;
        pend_valid  <= 1'b1;
      end else if (out_load) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Display value for the current mode.
  always_comb begin
    case (mode_sel)
      MODE_HIGH_DUTY: shown = pct_of_255(high_duty);
      MODE_LOW_DUTY:  shown = pct_of_255(low_duty);
      MODE_MONITOR:   shown = pct_of_1023(low_duty);
      MODE_CURRENT:   shown = current_lvl;
      default:        shown = pct_of_255(voltage_lvl);
    endcase
  end

  // Decimal digits; the value never reaches 200.
  assign hundreds = (shown >= 7'd100);
  assign rem_hund = hundreds ? shown - 7'd100 : shown;
  assign tens     = div_by_ten(rem_hund);
  assign units    = 4'(rem_hund - 7'(tens) * 7'd10);

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      mode            <= mode_sel;
      duty_high_side  <= high_duty;
      duty_low_side   <= low_duty;
      current_level   <= current_lvl;
      voltage_level   <= voltage_lvl;
      shown_value     <= shown;
      digit_thousands <= 4'd0;
      digit_hundreds  <= {3'b000, hundreds};
      digit_tens      <= tens;
      digit_units     <= units;
      point_on        <= (mode_sel == MODE_VOLTAGE);
    end
  end

endmodule
